@@ src/msct_pkg.sv @@
// ----------------------------------------------------------------------------
// msct_pkg
// Shared types and constants for the soft timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package msct_pkg;

    localparam int CNT_W     = 14;
    localparam int OP_W      = 3;
    localparam int CH_W      = 4;
    localparam int THR_W     = 16;
    localparam int CH_CMP_W  = 7;

    localparam logic [CNT_W-1:0] TICK_LIMIT = 14'd9000;

    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_START      = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP       = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP_ALL   = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK_LOOP = 3'd4;
    localparam logic [OP_W-1:0] OP_CHECK_ONCE = 3'd5;

    typedef struct packed {
        logic             run;
        logic [CNT_W-1:0] count;
    } t_chan;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CH_W-1:0]  channel;
        logic [THR_W-1:0] threshold;
    } t_cmd;

endpackage

`default_nettype wire

@@ src/msct_cell.sv @@
// ----------------------------------------------------------------------------
// msct_cell
// One channel slot of the rotating ring: run flag and tick count.
// ----------------------------------------------------------------------------
`default_nettype none

module msct_cell
    import msct_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_shift,
    input  wire t_chan i_chan,
    output t_chan      o_chan
);

    t_chan r_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
        end else if (i_shift) begin
            r_chan <= i_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

`default_nettype wire

@@ src/msct_head.sv @@
// ----------------------------------------------------------------------------
// msct_head
// Update stage at the ring head: applies the current op to the slot passing.
// ----------------------------------------------------------------------------
`default_nettype none

module msct_head
    import msct_pkg::*;
(
    input  wire t_cmd                 i_cmd,
    input  wire logic [CH_CMP_W-1:0]  i_pos,
    input  wire t_chan                i_chan,
    output t_chan                     o_chan,
    output logic                      o_hit
);

    logic w_sel;
    logic w_reach;

    assign w_sel   = (i_pos == CH_CMP_W'(i_cmd.channel));
    assign w_reach = ({{(THR_W-CNT_W){1'b0}}, i_chan.count} >= i_cmd.threshold);

    always_comb begin
        o_chan = i_chan;
        o_hit  = 1'b0;
        case (i_cmd.op)
            OP_TICK: begin
                if (i_chan.run && (i_chan.count < TICK_LIMIT)) begin
                    o_chan.count = i_chan.count + CNT_W'(1);
                end
            end
            OP_START: begin
                if (w_sel) begin
                    o_chan.count = '0;
                    o_chan.run   = 1'b1;
                end
            end
            OP_STOP: begin
                if (w_sel) begin
                    o_chan.run = 1'b0;
                end
            end
            OP_STOP_ALL: begin
                o_chan.run = 1'b0;
            end
            OP_CHECK_LOOP: begin
                if (w_sel && i_chan.run && w_reach) begin
                    o_hit        = 1'b1;
                    o_chan.count = '0;
                end
            end
            OP_CHECK_ONCE: begin
                if (w_sel && i_chan.run && w_reach) begin
                    o_hit      = 1'b1;
                    o_chan.run = 1'b0;
                end
            end
            default: begin
                o_chan = i_chan;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/multi_channel_soft_timer_bank.sv @@
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_bank
// Bank of tick counters held in a ring of channel cells that rotates once
// per op past a single update stage.
//
//   channel  dir  handshake          words
//   in       in   i_valid / o_stall  i_op, i_channel, i_threshold
//   out      out  o_valid / i_stall  o_expired
//
// An op is accepted, then the ring makes one full turn through the head
// update stage, one channel per cycle except that the last step can wait on
// i_stall; a new op is not accepted until the turn ends.
// The result is loaded into an output register on the last turn step; that
// step waits while the previous result is still held by i_stall.
// A new op is taken at the edge after the turn ends, even while a result waits.
// Synchronous reset clears every channel.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_soft_timer_bank
    import msct_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [OP_W-1:0]  i_op,
    input  wire logic [CH_W-1:0]  i_channel,
    input  wire logic [THR_W-1:0] i_threshold,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_expired
);

    localparam int PW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [PW-1:0] POS_LAST = PW'(CHANNELS - 1);

    logic          r_busy;
    logic [PW-1:0] r_pos;
    t_cmd          r_cmd;
    logic          r_hit;
    logic          r_out_valid;
    logic          r_expired;

    logic  w_in_acc;
    logic  w_out_acc;
    logic  w_last;
    logic  w_slot_free;
    logic  w_adv;
    logic  w_hit;
    t_chan w_head_out;
    t_chan w_cell_q [CHANNELS];

    assign w_in_acc    = i_valid && !r_busy;
    assign w_out_acc   = r_out_valid && !i_stall;
    assign w_last      = (r_pos == POS_LAST);
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_adv       = r_busy && (!w_last || w_slot_free);

    for (genvar k = 0; k < CHANNELS; k++) begin : g_ring
        t_chan w_feed;
        if (k == CHANNELS - 1) begin : g_tail
            assign w_feed = w_head_out;
        end else begin : g_mid
            assign w_feed = w_cell_q[k+1];
        end
        msct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_adv),
            .i_chan  (w_feed),
            .o_chan  (w_cell_q[k])
        );
    end

    msct_head u_head (
        .i_cmd  (r_cmd),
        .i_pos  (CH_CMP_W'(r_pos)),
        .i_chan (w_cell_q[0]),
        .o_chan (w_head_out),
        .o_hit  (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
                r_hit  <= 1'b0;
            end else if (w_adv) begin
                r_hit <= r_hit | w_hit;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_pos  <= '0;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
            if (w_adv && w_last) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd.op        <= i_op;
            r_cmd.channel   <= i_channel;
            r_cmd.threshold <= i_threshold;
        end
        if (w_adv && w_last) begin
            r_expired <= r_hit | w_hit;
        end
    end

    assign o_stall   = r_busy;
    assign o_valid   = r_out_valid;
    assign o_expired = r_expired;

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_pos == '0))
        else $error("ring position not parked while idle");

    a_start_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_busy && (r_pos == '0)))
        else $error("accepted op did not start a ring turn");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_last) |=> (o_valid && !r_busy))
        else $error("end of turn did not load a result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_last && r_out_valid && i_stall) |-> !w_adv)
        else $error("result slot overwritten while held");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the soft timer bank. A short table of directed
// words comes first, then a gap-free run of ticks on two started channels,
// then random words. Each accepted word updates a local copy of the bank,
// and every result is compared with that copy's value, or with the row's want bit if typed.
// Both sides idle at random, and the receiver holds off for a long stretch
// once to back the block up.
// ----------------------------------------------------------------------------
module testbench;
    import msct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS   = 16;
    localparam int IDLE_PCT   = 32;
    localparam int RAND_WORDS = 430;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 400;
    localparam int RUN_TICKS  = 40;
    localparam int LIMIT      = 1_000_000;

    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    typedef struct packed {
        t_cmd w;
        logic typed;
        logic want;
    } t_row;

    // typed rows: result readable straight from the op semantics
    localparam t_row SCRIPT [22] = '{
        '{'{OP_CHECK_LOOP, 4'd0,  16'd0},     1'b1, 1'b0},
        '{'{OP_TICK,       4'd0,  16'd0},     1'b1, 1'b0},
        '{'{OP_START,      4'd0,  16'hFFFF},  1'b1, 1'b0},
        '{'{OP_START,      4'd15, 16'd0},     1'b1, 1'b0},
        '{'{OP_CHECK_ONCE, 4'd0,  16'd0},     1'b1, 1'b1},
        '{'{OP_CHECK_ONCE, 4'd0,  16'd0},     1'b1, 1'b0},
        '{'{OP_START,      4'd0,  16'd0},     1'b1, 1'b0},
        '{'{OP_TICK,       4'd9,  16'd77},    1'b1, 1'b0},
        '{'{OP_TICK,       4'd0,  16'd0},     1'b1, 1'b0},
        '{'{OP_TICK,       4'd15, 16'hFFFF},  1'b1, 1'b0},
        '{'{OP_CHECK_LOOP, 4'd15, 16'd4},     1'b0, 1'b0},
        '{'{OP_CHECK_LOOP, 4'd15, 16'd3},     1'b0, 1'b0},
        '{'{OP_CHECK_LOOP, 4'd15, 16'd1},     1'b0, 1'b0},
        '{'{OP_STOP,       4'd15, 16'd0},     1'b1, 1'b0},
        '{'{OP_TICK,       4'd3,  16'd0},     1'b1, 1'b0},
        '{'{OP_CHECK_LOOP, 4'd15, 16'd0},     1'b1, 1'b0},
        '{'{OP_SPARE6,     4'd7,  16'hFFFF},  1'b1, 1'b0},
        '{'{OP_SPARE7,     4'd8,  16'd0},     1'b1, 1'b0},
        '{'{OP_CHECK_ONCE, 4'd0,  16'hFFFF},  1'b0, 1'b0},
        '{'{OP_STOP_ALL,   4'd9,  16'h5A5A},  1'b1, 1'b0},
        '{'{OP_CHECK_LOOP, 4'd0,  16'd0},     1'b1, 1'b0},
        '{'{OP_START,      4'd5,  16'hFFFF},  1'b1, 1'b0}
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic [OP_W-1:0]  i_op        = OP_TICK;
    logic [CH_W-1:0]  i_channel   = '0;
    logic [THR_W-1:0] i_threshold = '0;
    logic             i_stall     = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic             o_expired;

    logic [CNT_W-1:0] ticks [CHANNELS];
    logic             live  [CHANNELS];
    logic             expired_q [$];

    logic quiet   = 1'b0;
    logic rx_hold = 1'b0;
    bit   hold_go = 1'b0;
    bit   want_bit;
    int   errors       = 0;
    int   words_sent   = 0;
    int   results_seen = 0;
    int   hits_seen    = 0;
    int   cycles       = 0;

    multi_channel_soft_timer_bank #(
        .CHANNELS(CHANNELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_channel  (i_channel),
        .i_threshold(i_threshold),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_expired  (o_expired)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic got, input logic want);
        if (errors < 30) begin
            $display("mismatch at cycle %0d: %s (got %b, want %b)", cycles, what, got, want);
        end
        errors++;
    endtask

    function automatic logic timer_outcome(input t_cmd w);
        logic hit;
        hit = 1'b0;
        case (w.op)
            OP_TICK: begin
                for (int k = 0; k < CHANNELS; k++) begin
                    if (live[k] && ticks[k] < TICK_LIMIT) ticks[k] = ticks[k] + CNT_W'(1);
                end
            end
            OP_START: begin
                if (w.channel < CHANNELS) begin
                    ticks[w.channel] = '0;
                    live[w.channel]  = 1'b1;
                end
            end
            OP_STOP: begin
                if (w.channel < CHANNELS) live[w.channel] = 1'b0;
            end
            OP_STOP_ALL: begin
                for (int k = 0; k < CHANNELS; k++) live[k] = 1'b0;
            end
            OP_CHECK_LOOP, OP_CHECK_ONCE: begin
                if (w.channel < CHANNELS && live[w.channel]
                        && {2'b00, ticks[w.channel]} >= w.threshold) begin
                    hit = 1'b1;
                    if (w.op == OP_CHECK_LOOP) ticks[w.channel] = '0;
                    else live[w.channel] = 1'b0;
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    function automatic t_cmd random_word();
        t_cmd w;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 35)      w.op = OP_TICK;
        else if (pick < 50) w.op = OP_START;
        else if (pick < 58) w.op = OP_STOP;
        else if (pick < 61) w.op = OP_STOP_ALL;
        else if (pick < 78) w.op = OP_CHECK_LOOP;
        else if (pick < 95) w.op = OP_CHECK_ONCE;
        else if (pick < 98) w.op = OP_SPARE6;
        else                w.op = OP_SPARE7;
        // most traffic on a few channels so checks find them running
        w.channel = ($urandom_range(99) < 70) ? CH_W'($urandom_range(3))
                                              : CH_W'($urandom_range(15));
        w.threshold = ($urandom_range(9) < 8) ? THR_W'($urandom_range(24))
                                              : THR_W'($urandom_range(16'hFFFF));
        return w;
    endfunction

    task automatic push_word(input t_cmd w, input logic typed, input logic want);
        logic guess;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= w.op;
        i_channel   <= w.channel;
        i_threshold <= w.threshold;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        guess = timer_outcome(w);
        expired_q.push_back(typed ? want : guess);
        words_sent++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (rx_hold) begin
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_expired === 1'b1) hits_seen++;
            if (expired_q.size() == 0) begin
                report_mismatch("result word with nothing pending", o_expired, 1'bx);
            end else begin
                want_bit = expired_q.pop_front();
                if (o_expired !== want_bit) report_mismatch("expired", o_expired, want_bit);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, expired_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        t_cmd w;
        for (int k = 0; k < CHANNELS; k++) begin
            ticks[k] = '0;
            live[k]  = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SCRIPT[r]) push_word(SCRIPT[r].w, SCRIPT[r].typed, SCRIPT[r].want);

        // gap-free run of ticks on two channels, then checks around the count
        quiet <= 1'b1;
        push_word('{OP_START, 4'd3, 16'd0}, 1'b1, 1'b0);
        push_word('{OP_START, 4'd12, 16'd0}, 1'b1, 1'b0);
        repeat (RUN_TICKS) push_word('{OP_TICK, 4'd0, 16'd0}, 1'b0, 1'b0);
        push_word('{OP_CHECK_LOOP, 4'd3, THR_W'(RUN_TICKS + 1)}, 1'b0, 1'b0);
        push_word('{OP_CHECK_ONCE, 4'd3, THR_W'(RUN_TICKS)}, 1'b0, 1'b0);
        push_word('{OP_CHECK_LOOP, 4'd12, THR_W'(RUN_TICKS)}, 1'b0, 1'b0);
        push_word('{OP_CHECK_LOOP, 4'd12, 16'd0}, 1'b0, 1'b0);
        quiet <= 1'b0;

        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == HOLD_AT) hold_go = 1'b1;
            w = random_word();
            push_word(w, 1'b0, 1'b0);
        end
        i_valid <= 1'b0;

        while (expired_q.size() != 0) @(posedge i_clk);
        repeat (3 * CHANNELS) @(posedge i_clk);

        $display("sent %0d words incl. a gap-free run of %0d ticks; %0d results, %0d expiries",
                 words_sent, RUN_TICKS, results_seen, hits_seen);
        $display("covered all ops, spare op codes, zero and full thresholds, long output hold");
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
